// ===== design/cs565_pkg.sv =====
// ---------------------------------------------------------------------------
// cs565_pkg
// Shared types and constants for the color space to RGB565 converter.
// ---------------------------------------------------------------------------
`default_nettype none

package cs565_pkg;

	typedef enum logic [1:0] {
		MODE_RGB  = 2'd0,
		MODE_HSV  = 2'd1,
		MODE_HSL  = 2'd2,
		MODE_CMYK = 2'd3
	} mode_t;

	localparam int NUM_W = 27;
	localparam int VAL_W = 33;

	// common denominator 2 * 255 * 255 * 960
	localparam logic [NUM_W-1:0] DEN = 27'd124848000;

	// floor(2^43 / DEN), applied to the value shifted right by 12
	localparam logic [63:0] RECIP_FULL = (64'd1 << 43) / 64'(DEN);
	localparam logic [16:0] RECIP      = RECIP_FULL[16:0];

	localparam logic [16:0] HUE_BIAS    = 17'd1792;
	localparam logic [9:0]  HUE_SECTOR  = 10'd960;
	localparam logic [12:0] HUE_RECIP   = 13'd4370;
	localparam logic [5:0]  SEXT_RECIP  = 6'd43;
	localparam logic [6:0]  SECTORS     = 7'd6;
	localparam logic [10:0] CMYK_SCALE  = 11'd1920;
	localparam logic [7:0]  LEVEL_MAX   = 8'd255;

	localparam logic [5:0]  RED_MAX     = 6'd31;
	localparam logic [5:0]  GREEN_MAX   = 6'd63;
	localparam logic [5:0]  BLUE_MAX    = 6'd31;

endpackage

`default_nettype wire

// ===== design/cs565_chan_div.sv =====
// ---------------------------------------------------------------------------
// cs565_chan_div
// Scales one channel numerator by its maximum and divides by the common
// denominator: reciprocal estimate, then one correction step. Two register
// stages; the quotient is combinational from the second.
// ---------------------------------------------------------------------------
`default_nettype none

module cs565_chan_div (
	input  wire logic                          clk,
	input  wire logic [cs565_pkg::NUM_W-1:0]   num,
	input  wire logic [5:0]                    chan_max,
	output logic      [5:0]                    quot
);

	logic [cs565_pkg::VAL_W-1:0] val_s4;
	logic [cs565_pkg::VAL_W-1:0] val_s5;
	logic [5:0]                  qest_s5;

	logic [37:0]                 qprod;
	logic [cs565_pkg::VAL_W-1:0] qden;
	logic [cs565_pkg::VAL_W-1:0] rem;
	logic                        bump;
	logic [6:0]                  q7;

	assign qprod = 38'(val_s4[32:12]) * 38'(cs565_pkg::RECIP);

	always_ff @(posedge clk) begin
		val_s4  <= 33'(num) * 33'(chan_max);
		val_s5  <= val_s4;
		qest_s5 <= qprod[36:31];
	end

	// estimate is low by at most one
	assign qden = 33'(qest_s5) * 33'(cs565_pkg::DEN);
	assign rem  = val_s5 - qden;
	assign bump = (rem >= 33'(cs565_pkg::DEN));
	assign q7   = {1'b0, qest_s5} + 7'(bump);

	always_comb begin
		if (q7 > {1'b0, chan_max}) begin
			quot = chan_max;
		end else begin
			quot = q7[5:0];
		end
	end

endmodule

`default_nettype wire

// ===== design/color_space_to_rgb565.sv =====
// ---------------------------------------------------------------------------
// color_space_to_rgb565
// Converts one pixel from RGB, HSV, HSL or CMYK into a packed RGB565 word.
//
// Requests enter on start with hue_sixteenths and level_one..level_four;
// busy is always low, so a request is taken on every cycle start is high.
// The source color space comes from the mode register, written through
// cfg_we / cfg_wdata; the user must write it only while no request is in
// flight, and the block does not enforce this. Each result appears on
// packed_color with done high for exactly one cycle, after the register
// stages listed below; the receiver cannot stall. Throughput is one request per
// clock: six register stages (input products, hue sector split, channel
// numerators, scale, reciprocal estimate, output) each hold a different request.
// Reset clears the stage valid bits and sets the mode to RGB; requests in
// flight at reset are dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module color_space_to_rgb565 (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_wdata,
	input  wire logic signed [15:0] hue_sixteenths,
	input  wire logic [7:0]         level_one,
	input  wire logic [7:0]         level_two,
	input  wire logic [7:0]         level_three,
	input  wire logic [7:0]         level_four,
	output logic                    done,
	output logic [15:0]             packed_color
);

	cs565_pkg::mode_t mode_q;

	// stage valid bits
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic done_q;
	logic [15:0] packed_q;

	// stage 1
	logic [16:0] hue_adj;
	logic [23:0] hprod;
	logic [8:0]  twol;
	logic [7:0]  lum_dist;
	logic [7:0]  cmul;
	logic [15:0] cp;
	logic [7:0]  kk;

	cs565_pkg::mode_t mode_s1;
	logic [16:0] hue_adj_s1;
	logic [6:0]  hq_s1;
	logic [15:0] cp_s1;
	logic [7:0]  v_s1;
	logic [15:0] cm_r_s1, cm_g_s1, cm_b_s1;
	logic [15:0] rgb_s1;

	// stage 2
	logic [12:0] sixth;
	logic [6:0]  sector_full;
	logic [16:0] hq960;
	logic [16:0] fdiff;
	logic [9:0]  fpos;
	logic [15:0] v255;

	cs565_pkg::mode_t mode_s2;
	logic [2:0]  sector_s2;
	logic [9:0]  x_s2;
	logic [16:0] c2_s2;
	logic [16:0] m2_s2;
	logic [15:0] cm_r_s2, cm_g_s2, cm_b_s2;
	logic [15:0] rgb_s2;

	// stage 3
	logic [cs565_pkg::NUM_W-1:0] cx, cf, mf;
	logic [cs565_pkg::NUM_W-1:0] comp_r, comp_g, comp_b;

	cs565_pkg::mode_t mode_s3, mode_s4, mode_s5;
	logic [cs565_pkg::NUM_W-1:0] n_r_s3, n_g_s3, n_b_s3;
	logic [15:0] rgb_s3, rgb_s4, rgb_s5;

	logic [5:0] q_r, q_g, q_b;

	assign busy = 1'b0;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= cs565_pkg::MODE_RGB;
		end else if (cfg_we) begin
			mode_q <= cs565_pkg::mode_t'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			done_q   <= valid_s5;
		end
	end

	// stage 1: hue bias into a positive range, sector quotient, level products
	assign hue_adj = {1'b0, ~hue_sixteenths[15], hue_sixteenths[14:0]} + cs565_pkg::HUE_BIAS;
	assign hprod   = 24'(hue_adj[16:6]) * 24'(cs565_pkg::HUE_RECIP);
	assign twol    = {level_three, 1'b0};

	always_comb begin
		if (twol >= 9'(cs565_pkg::LEVEL_MAX)) begin
			lum_dist = 8'(twol - 9'(cs565_pkg::LEVEL_MAX));
		end else begin
			lum_dist = 8'(9'(cs565_pkg::LEVEL_MAX) - twol);
		end
		if (mode_q == cs565_pkg::MODE_HSL) begin
			cmul = cs565_pkg::LEVEL_MAX - lum_dist;
		end else begin
			cmul = level_three;
		end
	end

	assign cp = cmul * level_two;
	assign kk = cs565_pkg::LEVEL_MAX - level_four;

	always_ff @(posedge clk) begin
		mode_s1    <= mode_q;
		hue_adj_s1 <= hue_adj;
		hq_s1      <= hprod[22:16];
		cp_s1      <= cp;
		v_s1       <= level_three;
		cm_r_s1    <= (cs565_pkg::LEVEL_MAX - level_one) * kk;
		cm_g_s1    <= (cs565_pkg::LEVEL_MAX - level_two) * kk;
		cm_b_s1    <= (cs565_pkg::LEVEL_MAX - level_three) * kk;
		rgb_s1     <= {level_one[7:3], level_two[7:2], level_three[7:3]};
	end

	// stage 2: sector and position, chroma and offset over the common denominator
	assign sixth       = 13'(hq_s1) * 13'(cs565_pkg::SEXT_RECIP);
	assign sector_full = hq_s1 - ({3'b000, sixth[11:8]} * cs565_pkg::SECTORS);
	assign hq960       = 17'(hq_s1) * 17'(cs565_pkg::HUE_SECTOR);
	assign fdiff       = hue_adj_s1 - hq960;
	assign fpos        = fdiff[9:0];
	assign v255        = {v_s1, 8'h00} - {8'h00, v_s1};

	always_ff @(posedge clk) begin
		mode_s2   <= mode_s1;
		sector_s2 <= sector_full[2:0];
		x_s2      <= sector_full[0] ? (cs565_pkg::HUE_SECTOR - fpos) : fpos;
		c2_s2     <= {cp_s1, 1'b0};
		if (mode_s1 == cs565_pkg::MODE_HSL) begin
			m2_s2 <= {v255, 1'b0} - {1'b0, cp_s1};
		end else begin
			m2_s2 <= {v255 - cp_s1, 1'b0};
		end
		cm_r_s2   <= cm_r_s1;
		cm_g_s2   <= cm_g_s1;
		cm_b_s2   <= cm_b_s1;
		rgb_s2    <= rgb_s1;
	end

	// stage 3: channel numerators
	assign cx = 27'(c2_s2) * 27'(x_s2);
	assign cf = 27'(c2_s2) * 27'(cs565_pkg::HUE_SECTOR);
	assign mf = 27'(m2_s2) * 27'(cs565_pkg::HUE_SECTOR);

	always_comb begin
		case (sector_s2)
			3'd0: begin
				comp_r = cf;   comp_g = cx;   comp_b = '0;
			end
			3'd1: begin
				comp_r = cx;   comp_g = cf;   comp_b = '0;
			end
			3'd2: begin
				comp_r = '0;   comp_g = cf;   comp_b = cx;
			end
			3'd3: begin
				comp_r = '0;   comp_g = cx;   comp_b = cf;
			end
			3'd4: begin
				comp_r = cx;   comp_g = '0;   comp_b = cf;
			end
			default: begin
				comp_r = cf;   comp_g = '0;   comp_b = cx;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mode_s3 <= mode_s2;
		rgb_s3  <= rgb_s2;
		if (mode_s2 == cs565_pkg::MODE_CMYK) begin
			n_r_s3 <= 27'(cm_r_s2) * 27'(cs565_pkg::CMYK_SCALE);
			n_g_s3 <= 27'(cm_g_s2) * 27'(cs565_pkg::CMYK_SCALE);
			n_b_s3 <= 27'(cm_b_s2) * 27'(cs565_pkg::CMYK_SCALE);
		end else begin
			n_r_s3 <= comp_r + mf;
			n_g_s3 <= comp_g + mf;
			n_b_s3 <= comp_b + mf;
		end
	end

	// stages 4 and 5: scale and divide per channel
	always_ff @(posedge clk) begin
		mode_s4 <= mode_s3;
		mode_s5 <= mode_s4;
		rgb_s4  <= rgb_s3;
		rgb_s5  <= rgb_s4;
	end

	cs565_chan_div u_div_r (
		.clk      (clk),
		.num      (n_r_s3),
		.chan_max (cs565_pkg::RED_MAX),
		.quot     (q_r)
	);

	cs565_chan_div u_div_g (
		.clk      (clk),
		.num      (n_g_s3),
		.chan_max (cs565_pkg::GREEN_MAX),
		.quot     (q_g)
	);

	cs565_chan_div u_div_b (
		.clk      (clk),
		.num      (n_b_s3),
		.chan_max (cs565_pkg::BLUE_MAX),
		.quot     (q_b)
	);

	// output register
	always_ff @(posedge clk) begin
		if (mode_s5 == cs565_pkg::MODE_RGB) begin
			packed_q <= rgb_s5;
		end else begin
			packed_q <= {q_r[4:0], q_g, q_b[4:0]};
		end
	end

	assign done         = done_q;
	assign packed_color = packed_q;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for color_space_to_rgb565. Pixels are sent in every
// color space mode, first a few directed corner cases and then random
// pixels, with random sender gaps in parts of the first six phases. A
// scoreboard predicts each RGB565 word from the accepted request and the
// current mode and checks every result in order.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;

	localparam int HUE_TURN    = 5760;
	localparam int SECTOR_SPAN = 960;
	localparam int RUN_LIMIT   = 400000;
	localparam int PHASE_LEN   = 250;

	typedef struct packed {
		cs565_pkg::mode_t mode;
		logic [15:0]      color;
	} pixel_t;

	class pixel_scoreboard;
		cs565_pkg::mode_t mode;
		pixel_t           pending_q[$];
		int               mismatches;
		int               matched;

		function new();
			mode = cs565_pkg::MODE_RGB;
			mismatches = 0;
			matched = 0;
		endfunction

		static function longint unsigned scale_level(longint unsigned num,
				longint unsigned den, longint unsigned top);
			longint unsigned q;
			q = (num * top) / den;
			return (q > top) ? top : q;
		endfunction

		static function logic [15:0] pack(longint unsigned r, longint unsigned g,
				longint unsigned b);
			return {r[4:0], g[5:0], b[4:0]};
		endfunction

		static function logic [15:0] hue_pixel(int hue, longint unsigned chroma,
				longint unsigned offset, longint unsigned den);
			int              sector;
			longint unsigned frac;
			longint unsigned cfull;
			longint unsigned xpart;
			longint unsigned base;
			longint unsigned r, g, b;
			sector = hue / SECTOR_SPAN;
			frac = longint'(hue % SECTOR_SPAN);
			cfull = chroma * SECTOR_SPAN;
			xpart = sector[0] ? chroma * (SECTOR_SPAN - frac) : chroma * frac;
			base = offset * SECTOR_SPAN;
			case (sector)
				0: begin r = cfull; g = xpart; b = 0; end
				1: begin r = xpart; g = cfull; b = 0; end
				2: begin r = 0; g = cfull; b = xpart; end
				3: begin r = 0; g = xpart; b = cfull; end
				4: begin r = xpart; g = 0; b = cfull; end
				default: begin r = cfull; g = 0; b = xpart; end
			endcase
			return pack(scale_level(r + base, den, 31), scale_level(g + base, den, 63),
				scale_level(b + base, den, 31));
		endfunction

		static function logic [15:0] convert_pixel(cs565_pkg::mode_t m,
				logic signed [15:0] h, logic [7:0] l1, logic [7:0] l2, logic [7:0] l3,
				logic [7:0] l4);
			int              hue;
			longint unsigned a, s, v, k;
			longint unsigned chroma, twol, lum_dist, half, kk;
			hue = ((int'(h) % HUE_TURN) + HUE_TURN) % HUE_TURN;
			a = l1;
			s = l2;
			v = l3;
			k = l4;
			case (m)
				cs565_pkg::MODE_RGB: return pack(a >> 3, s >> 2, v >> 3);
				cs565_pkg::MODE_HSV: begin
					chroma = v * s;
					return hue_pixel(hue, chroma, v * 255 - chroma, 255 * 255 * SECTOR_SPAN);
				end
				cs565_pkg::MODE_HSL: begin
					twol = 2 * v;
					lum_dist = (twol >= 255) ? twol - 255 : 255 - twol;
					half = (255 - lum_dist) * s;
					return hue_pixel(hue, 2 * half, twol * 255 - half,
						2 * 255 * 255 * SECTOR_SPAN);
				end
				default: begin
					kk = 255 - k;
					return pack(scale_level((255 - a) * kk, 255 * 255, 31),
						scale_level((255 - s) * kk, 255 * 255, 63),
						scale_level((255 - v) * kk, 255 * 255, 31));
				end
			endcase
		endfunction

		function void note_request(logic signed [15:0] h, logic [7:0] l1, logic [7:0] l2,
				logic [7:0] l3, logic [7:0] l4);
			pixel_t p;
			p.mode = mode;
			p.color = convert_pixel(mode, h, l1, l2, l3, l4);
			pending_q.push_back(p);
		endfunction

		function void check_pixel(logic [15:0] got);
			pixel_t p;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: packed_color 16'h%04h", got);
			end else begin
				p = pending_q.pop_front();
				if (got !== p.color) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: mode %0d expected 16'h%04h got 16'h%04h",
							p.mode, p.color, got);
				end else begin
					matched++;
				end
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               cfg_we;
	logic [1:0]         cfg_wdata;
	logic signed [15:0] hue_sixteenths;
	logic [7:0]         level_one;
	logic [7:0]         level_two;
	logic [7:0]         level_three;
	logic [7:0]         level_four;
	logic               done;
	logic [15:0]        packed_color;

	pixel_scoreboard sb;
	int              mode_writes;
	int              sent;
	bit              idling;

	color_space_to_rgb565 u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.hue_sixteenths (hue_sixteenths),
		.level_one      (level_one),
		.level_two      (level_two),
		.level_three    (level_three),
		.level_four     (level_four),
		.done           (done),
		.packed_color   (packed_color)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// accepted requests, mode writes and results, all seen at the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.mode = cs565_pkg::mode_t'(cfg_wdata);
			if (start && !busy)
				sb.note_request(hue_sixteenths, level_one, level_two, level_three, level_four);
			if (done)
				sb.check_pixel(packed_color);
		end
	end

	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("testbench: done, errors");
		$finish;
	end

	task automatic send_pixel(input logic signed [15:0] h, input logic [7:0] l1,
			input logic [7:0] l2, input logic [7:0] l3, input logic [7:0] l4);
		start <= 1'b1;
		hue_sixteenths <= h;
		level_one <= l1;
		level_two <= l2;
		level_three <= l3;
		level_four <= l4;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
		if (idling && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_mode(input cs565_pkg::mode_t m);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		mode_writes++;
	endtask

	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic signed [15:0] pick_hue();
		int h;
		case ($urandom_range(0, 5))
			0: h = int'($urandom_range(0, 6)) * SECTOR_SPAN + int'($urandom_range(0, 2)) - 1
				+ (int'($urandom_range(0, 8)) - 4) * HUE_TURN;
			1: h = $urandom_range(0, 1) ? -32768 : 32767;
			2: h = int'($urandom_range(0, HUE_TURN - 1)) - ($urandom_range(0, 1) ? HUE_TURN : 0);
			default: h = int'(16'($urandom)) - 32768;
		endcase
		return 16'(h);
	endfunction

	initial begin
		cs565_pkg::mode_t phase_mode;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = cs565_pkg::MODE_RGB;
		hue_sixteenths = '0;
		level_one = '0;
		level_two = '0;
		level_three = '0;
		level_four = '0;
		mode_writes = 0;
		sent = 0;
		idling = 1'b0;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		set_mode(cs565_pkg::MODE_RGB);
		send_pixel(16'sd0, 8'd0, 8'd0, 8'd0, 8'd255);
		send_pixel(-16'sd1, 8'd255, 8'd255, 8'd255, 8'd0);
		set_mode(cs565_pkg::MODE_HSV);
		send_pixel(16'sd0, 8'd0, 8'd255, 8'd255, 8'd0);
		send_pixel(16'sd959, 8'd255, 8'd255, 8'd255, 8'd0);
		send_pixel(16'sd960, 8'd0, 8'd255, 8'd255, 8'd0);
		send_pixel(16'sd5759, 8'd0, 8'd255, 8'd255, 8'd0);
		send_pixel(16'sd5760, 8'd0, 8'd255, 8'd255, 8'd0);
		send_pixel(-16'sd1, 8'd0, 8'd255, 8'd255, 8'd0);
		send_pixel(-16'sd32768, 8'd0, 8'd255, 8'd255, 8'd255);
		send_pixel(16'sd32767, 8'd0, 8'd255, 8'd255, 8'd0);
		send_pixel(16'sd2000, 8'd0, 8'd0, 8'd200, 8'd0);
		send_pixel(16'sd3000, 8'd0, 8'd255, 8'd0, 8'd0);
		set_mode(cs565_pkg::MODE_HSL);
		send_pixel(16'sd0, 8'd0, 8'd255, 8'd127, 8'd0);
		send_pixel(16'sd1920, 8'd0, 8'd255, 8'd128, 8'd0);
		send_pixel(16'sd4800, 8'd0, 8'd255, 8'd0, 8'd0);
		send_pixel(16'sd3000, 8'd0, 8'd255, 8'd255, 8'd0);
		send_pixel(-16'sd961, 8'd0, 8'd0, 8'd200, 8'd0);
		set_mode(cs565_pkg::MODE_CMYK);
		send_pixel(16'sd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_pixel(16'sd0, 8'd0, 8'd0, 8'd0, 8'd255);
		send_pixel(16'sd100, 8'd255, 8'd255, 8'd255, 8'd0);
		send_pixel(16'sd0, 8'd128, 8'd64, 8'd1, 8'd127);

		// random pixels, one mode per phase; no sender gaps in the last phases
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: phase_mode = cs565_pkg::MODE_HSV;
				1: phase_mode = cs565_pkg::MODE_HSL;
				2: phase_mode = cs565_pkg::MODE_CMYK;
				3: phase_mode = cs565_pkg::MODE_RGB;
				default: phase_mode = cs565_pkg::mode_t'($urandom_range(0, 3));
			endcase
			set_mode(phase_mode);
			for (int i = 0; i < PHASE_LEN; i++) begin
				idling = (ph < 6) && ((i / 40) % 3 != 2);
				send_pixel(pick_hue(), pick_level(), pick_level(), pick_level(), pick_level());
			end
			idling = 1'b0;
		end
		drain();

		$display("testbench: %0d pixels sent, %0d results matched, %0d mode writes",
			sent, sb.matched, mode_writes);
		$display("testbench: rgb, hsv, hsl and cmyk covered with hue wrap and sector edges");
		if (sb.mismatches == 0 && sb.pending_q.size() == 0 && sb.matched == sent)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

// ===== color_space_to_rgb565.f =====
design/cs565_pkg.sv
design/cs565_chan_div.sv
design/color_space_to_rgb565.sv
sim/testbench.sv
